// ===== src/sdas_pkg.sv =====
// Shared types and constants for the steering deadzone, authority and slew block.
package sdas_pkg;

  localparam logic [14:0] DzCap    = 15'd32735;
  localparam logic [15:0] Q15One   = 16'h8000;
  localparam logic [16:0] AlphaOne = 17'h10000;
  localparam logic [14:0] MagMax   = 15'h7FFF;

  typedef enum logic [2:0] {
    CfgDeadzone  = 3'd0,
    CfgFullSpeed = 3'd1,
    CfgMinSpeed  = 3'd2,
    CfgMinAuth   = 3'd3,
    CfgSlewRate  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [15:0] full_speed;
    logic [15:0] min_speed;
    logic [14:0] min_auth;
    logic [15:0] slew_rate;
  } cfg_t;

  // Classified sample as it waits in the queue
  typedef struct packed {
    logic        neg;
    logic        dz_zero;
    logic [31:0] dz_num;
    logic [15:0] dz_den;
    logic        ramp;
    logic [15:0] auth_fix;
    logic [31:0] auth_num;
    logic [15:0] auth_den;
    logic [15:0] dt;
  } item_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// ===== src/sdas_front.sv =====
// Front end: clamps the sample, classifies deadzone and speed band, forms dividends.
module sdas_front (
  input  logic        [15:0] raw_steer_i,
  input  logic        [16:0] speed_i,
  input  logic        [15:0] time_step_i,
  input  sdas_pkg::cfg_t     cfg_i,
  output sdas_pkg::item_t    item_o
);
  import sdas_pkg::*;

  logic        neg;
  logic [15:0] abs_raw;
  logic [14:0] mag;
  logic [14:0] dz;
  logic [15:0] spd;
  logic [15:0] auth_span;
  logic [15:0] spd_off;

  always_comb begin
    neg     = raw_steer_i[15];
    abs_raw = neg ? (~raw_steer_i + 16'd1) : raw_steer_i;
    // most negative code clamps to -32767
    mag     = (raw_steer_i == 16'h8000) ? MagMax : abs_raw[14:0];
    dz      = (cfg_i.deadzone > DzCap) ? DzCap : cfg_i.deadzone;
    spd     = speed_i[16] ? 16'd0 : speed_i[15:0];

    auth_span = Q15One - {1'b0, cfg_i.min_auth};
    spd_off   = spd - cfg_i.full_speed;

    item_o.neg      = neg;
    item_o.dz_zero  = (mag <= dz);
    item_o.dz_num   = {2'b00, 15'(mag - dz), 15'd0};
    item_o.dz_den   = Q15One - {1'b0, dz};
    item_o.ramp     = (spd > cfg_i.full_speed) && (spd < cfg_i.min_speed);
    item_o.auth_fix = (spd <= cfg_i.full_speed) ? Q15One : {1'b0, cfg_i.min_auth};
    item_o.auth_num = {16'd0, auth_span} * {16'd0, spd_off};
    item_o.auth_den = cfg_i.min_speed - cfg_i.full_speed;
    item_o.dt       = time_step_i;
  end

endmodule

// ===== src/sdas_fifo.sv =====
// Short queue of classified samples between front and back.
module sdas_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  sdas_pkg::item_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output sdas_pkg::item_t pop_data_o
);
  import sdas_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/sdas_div.sv =====
// Restoring divider, four quotient bits per cycle while step is set, 16-bit quotient in four steps.
module sdas_div (
  input  logic                clk_i,
  input  sdas_pkg::div_ctrl_t ctrl_i,
  input  logic         [31:0] num_i,
  input  logic         [15:0] den_i,
  output logic         [15:0] quo_o
);
  import sdas_pkg::*;

  // rem holds the partial remainder; shf carries dividend bits out and quotient bits in
  logic [15:0] rem_q, rem_d;
  logic [15:0] shf_q, shf_d;

  always_comb begin
    logic [16:0] trial;
    logic [15:0] r;
    logic [15:0] s;
    r = rem_q;
    s = shf_q;
    for (int i = 0; i < 4; i++) begin
      trial = {r, s[15]};
      if (trial >= {1'b0, den_i}) begin
        r = 16'(trial - {1'b0, den_i});
        s = {s[14:0], 1'b1};
      end else begin
        r = trial[15:0];
        s = {s[14:0], 1'b0};
      end
    end
    rem_d = r;
    shf_d = s;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= num_i[31:16];
      shf_q <= num_i[15:0];
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      shf_q <= shf_d;
    end
  end

  assign quo_o = shf_q;

endmodule

// ===== src/sdas_back.sv =====
// Back end: divisions, authority scaling, smoothing and the output register.
module sdas_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  sdas_pkg::item_t     item_i,
  input  logic         [15:0] slew_rate_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed  [15:0] steer_out_o,
  output logic signed  [15:0] steer_target_o
);
  import sdas_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StScale,
    StSmooth
  } state_e;

  state_e      state_q;
  logic [1:0]  cnt_q;
  item_t       item_q;
  logic [16:0] alpha_q;
  logic [15:0] target_q;
  logic [15:0] cur_q;
  logic        out_valid_q;
  logic [15:0] out_steer_q;
  logic [15:0] out_target_q;

  div_ctrl_t   div_ctrl;
  logic [15:0] dz_quo, auth_quo;

  logic [31:0] alpha_prod;
  logic [16:0] alpha_d;
  logic [15:0] auth;
  logic [15:0] dzmag;
  logic [31:0] scale_prod;
  logic [14:0] tmag;
  logic [15:0] tmag16;
  logic [15:0] target_d;
  logic        ge;
  logic [16:0] diff17;
  logic [32:0] step_prod;
  logic [15:0] step_mag;
  logic [15:0] cur_d;
  logic        out_free;
  logic        out_load;

  assign div_ctrl.load = (state_q == StIdle) && item_valid_i;
  assign div_ctrl.step = (state_q == StDiv);

  sdas_div u_div_dz (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (item_i.dz_num),
    .den_i  (item_q.dz_den),
    .quo_o  (dz_quo)
  );

  sdas_div u_div_auth (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (item_i.auth_num),
    .den_i  (item_q.auth_den),
    .quo_o  (auth_quo)
  );

  always_comb begin
    // smoothing fraction, saturated at one
    alpha_prod = {16'd0, item_q.dt} * {16'd0, slew_rate_i};
    alpha_d    = (alpha_prod[31:8] > {7'd0, AlphaOne}) ? AlphaOne : alpha_prod[24:8];

    auth       = item_q.ramp ? (Q15One - auth_quo) : item_q.auth_fix;
    dzmag      = item_q.dz_zero ? 16'd0 : dz_quo;
    scale_prod = {16'd0, dzmag} * {16'd0, auth};
    tmag       = (scale_prod[31:15] > {2'b00, MagMax}) ? MagMax : scale_prod[29:15];
    tmag16     = {1'b0, tmag};
    target_d   = item_q.neg ? (~tmag16 + 16'd1) : tmag16;

    ge        = ($signed(target_q) >= $signed(cur_q));
    diff17    = ge ? ({target_q[15], target_q} - {cur_q[15], cur_q})
                   : ({cur_q[15], cur_q} - {target_q[15], target_q});
    step_prod = {17'd0, diff17[15:0]} * {16'd0, alpha_q};
    step_mag  = step_prod[31:16];
    cur_d     = ge ? (cur_q + step_mag) : (cur_q - step_mag);

    out_free  = !out_valid_q || out_ready_i;
    out_load  = (state_q == StSmooth) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      item_q       <= '0;
      alpha_q      <= '0;
      target_q     <= '0;
      cur_q        <= '0;
      out_valid_q  <= 1'b0;
      out_steer_q  <= '0;
      out_target_q <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      unique case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            item_q  <= item_i;
            cnt_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          alpha_q <= alpha_d;
          cnt_q   <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= StScale;
          end
        end
        StScale: begin
          target_q <= target_d;
          state_q  <= StSmooth;
        end
        StSmooth: begin
          if (out_load) begin
            cur_q        <= cur_d;
            out_steer_q  <= cur_d;
            out_target_q <= target_q;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign item_ready_o   = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign steer_out_o    = $signed(out_steer_q);
  assign steer_target_o = $signed(out_target_q);

endmodule

// ===== src/steer_deadzone_authority_slew.sv =====
// Top level: steering deadzone rescale, speed-dependent authority and slew smoothing.
//
//  Channel  | Handshake                  | Beat contents
//  ---------+----------------------------+--------------------------------------------
//  input    | in_valid_i / in_ready_o    | raw_steer_i, speed_i, time_step_i
//  output   | out_valid_o / out_ready_i  | steer_out_o, steer_target_o
//  config   | cfg_we_i (no wait)         | cfg_index_i, cfg_wdata_i
//
//  Per beat the back end takes a sample off the queue, runs the two shared-width
//  radix-16 dividers (deadzone rescale and authority ramp, side by side), scales by
//  authority and smooths into the output; it takes a new sample only when idle.
//  Reset clears the queue, the back-end state and the kept steering value; the
//  configuration registers return to their defaults. No clearing pass is needed.
//  The queue lets the front keep taking samples while the back end works or the
//  output beat waits; the back end stalls only in its last step when the output
//  register is still full.
module steer_deadzone_authority_slew #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] raw_steer_i,
  input  logic signed [16:0] speed_i,
  input  logic        [15:0] time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] steer_out_o,
  output logic signed [15:0] steer_target_o,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [15:0] cfg_wdata_i
);
  import sdas_pkg::*;

  cfg_t  cfg_q;
  item_t front_item;
  item_t queue_item;
  logic  queue_valid;
  logic  back_ready;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone   <= 15'd3277;
      cfg_q.full_speed <= 16'd1000;
      cfg_q.min_speed  <= 16'd3000;
      cfg_q.min_auth   <= 15'd11469;
      cfg_q.slew_rate  <= 16'd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgDeadzone:  cfg_q.deadzone   <= cfg_wdata_i[14:0];
        CfgFullSpeed: cfg_q.full_speed <= cfg_wdata_i;
        CfgMinSpeed:  cfg_q.min_speed  <= cfg_wdata_i;
        CfgMinAuth:   cfg_q.min_auth   <= cfg_wdata_i[14:0];
        CfgSlewRate:  cfg_q.slew_rate  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: clamp, deadzone test, speed band, dividends
  sdas_front u_front (
    .raw_steer_i (raw_steer_i),
    .speed_i     (speed_i),
    .time_step_i (time_step_i),
    .cfg_i       (cfg_q),
    .item_o      (front_item)
  );

  // Decoupling queue; its space sets in_ready_o
  sdas_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_item)
  );

  // Back: divide, scale, smooth, hold the result beat
  sdas_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (queue_valid),
    .item_ready_o   (back_ready),
    .item_i         (queue_item),
    .slew_rate_i    (cfg_q.slew_rate),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .steer_out_o    (steer_out_o),
    .steer_target_o (steer_target_o)
  );

endmodule
